@@ rtl/core/utf8ld_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 lossy decoder package
// Shared item types, the command passed from front to back, and constants.
// ----------------------------------------------------------------------------
package utf8ld_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_in_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_replacement;
    logic       last_of_run;
    logic       end_of_stream;
    logic       stream_valid;
  } out_item_t;

  // One command covers all results of one input transaction: a number of
  // replacement characters followed by a number of passed-through bytes.
  typedef struct packed {
    logic [2:0]      n_rep;
    logic [2:0]      n_pass;
    logic [3:0][7:0] pbytes;
    logic            eos;
    logic            sv;
  } cmd_t;

  localparam int unsigned QDEPTH = 2;

  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [20:0] CP_SURR_LO  = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI  = 21'h00DFFF;
  localparam logic [20:0] CP_MIN2     = 21'h000080;
  localparam logic [20:0] CP_MIN3     = 21'h000800;
  localparam logic [20:0] CP_MIN4     = 21'h010000;
  localparam logic [7:0]  CONT_MASK   = 8'hC0;
  localparam logic [7:0]  CONT_TAG    = 8'h80;
  localparam logic [7:0]  PAYLOAD_MSK = 8'h3F;

endpackage

@@ rtl/core/utf8ld_front.sv @@
// ----------------------------------------------------------------------------
// UTF-8 lossy decoder front end
// Accepts bytes, tracks the pending sequence and issues one command per
// transaction that produces output.
// ----------------------------------------------------------------------------
module utf8ld_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  utf8ld_pkg::in_item_t in_data,
  input  logic                 q_full,
  output logic                 q_push,
  output utf8ld_pkg::cmd_t     q_cmd
);

  logic [2:0][7:0] hb_r, hb_nxt;
  logic [1:0]      hc_r, hc_nxt;
  logic [1:0]      nc_r, nc_nxt;
  logic            inv_r, inv_nxt;

  logic [7:0]  c;
  logic        last;
  logic        accept;
  logic        fresh_path;
  logic        is_cont;
  logic        do_fresh;
  logic [1:0]  extra;
  logic        seq_ok;
  logic [20:0] cp;

  assign c      = in_data.in_byte;
  assign last   = in_data.last_in_stream;
  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;

  assign fresh_path = (hc_r == 2'd0) || (nc_r == 2'd0);
  assign is_cont    = (c & utf8ld_pkg::CONT_MASK) == utf8ld_pkg::CONT_TAG;

  // Number of continuation bytes announced by a lead; zero if not a lead.
  always_comb begin
    if (c[7:5] == 3'b110) extra = 2'd1;
    else if (c[7:4] == 4'b1110) extra = 2'd2;
    else if (c[7:3] == 5'b11110) extra = 2'd3;
    else extra = 2'd0;
  end

  // Code point of the sequence completed by c, and its validity.
  always_comb begin
    unique case (hc_r)
      2'd1: cp = {10'd0, hb_r[0][4:0], c[5:0]};
      2'd2: cp = {5'd0, hb_r[0][3:0], hb_r[1][5:0], c[5:0]};
      2'd3: cp = {hb_r[0][2:0], hb_r[1][5:0], hb_r[2][5:0], c[5:0]};
      default: cp = '0;
    endcase
    seq_ok = 1'b1;
    if (hc_r == 2'd1 && cp < utf8ld_pkg::CP_MIN2) seq_ok = 1'b0;
    if (hc_r == 2'd2 && cp < utf8ld_pkg::CP_MIN3) seq_ok = 1'b0;
    if (hc_r == 2'd3 && cp < utf8ld_pkg::CP_MIN4) seq_ok = 1'b0;
    if (cp > utf8ld_pkg::CP_MAX) seq_ok = 1'b0;
    if (cp >= utf8ld_pkg::CP_SURR_LO && cp <= utf8ld_pkg::CP_SURR_HI) seq_ok = 1'b0;
  end

  always_comb begin
    q_cmd    = '0;
    hb_nxt   = hb_r;
    hc_nxt   = hc_r;
    nc_nxt   = nc_r;
    do_fresh = 1'b0;

    if (fresh_path) begin
      do_fresh = 1'b1;
    end else if (!is_cont) begin
      // Every held byte is re-decoded on its own and each fails.
      q_cmd.n_rep = {1'b0, hc_r};
      do_fresh    = 1'b1;
    end else if (nc_r == 2'd1) begin
      if (seq_ok) begin
        q_cmd.n_pass           = {1'b0, hc_r} + 3'd1;
        q_cmd.pbytes[0]        = hb_r[0];
        q_cmd.pbytes[1]        = hb_r[1];
        q_cmd.pbytes[2]        = hb_r[2];
        q_cmd.pbytes[hc_r]     = c;
      end else begin
        q_cmd.n_rep = {1'b0, hc_r} + 3'd1;
      end
      hb_nxt = '0;
      hc_nxt = 2'd0;
      nc_nxt = 2'd0;
    end else begin
      if (hc_r != 2'd3) hb_nxt[hc_r] = c;
      hc_nxt = hc_r + 2'd1;
      nc_nxt = nc_r - 2'd1;
      if (last) begin
        q_cmd.n_rep = {1'b0, hc_r} + 3'd1;
        hb_nxt = '0;
        hc_nxt = 2'd0;
        nc_nxt = 2'd0;
      end
    end

    if (do_fresh) begin
      hb_nxt = '0;
      hc_nxt = 2'd0;
      nc_nxt = 2'd0;
      if (!c[7]) begin
        q_cmd.n_pass    = 3'd1;
        q_cmd.pbytes[0] = c;
      end else if (extra == 2'd0 || last) begin
        q_cmd.n_rep = q_cmd.n_rep + 3'd1;
      end else begin
        hb_nxt[0] = c;
        hc_nxt    = 2'd1;
        nc_nxt    = extra;
      end
    end

    q_cmd.eos = last;
    q_cmd.sv  = last && !(inv_r || (q_cmd.n_rep != 3'd0));
    inv_nxt   = inv_r || (q_cmd.n_rep != 3'd0);

    // The end of a stream returns everything to the reset state.
    if (last) begin
      hb_nxt  = '0;
      hc_nxt  = 2'd0;
      nc_nxt  = 2'd0;
      inv_nxt = 1'b0;
    end
  end

  assign q_push = accept && ((q_cmd.n_rep != 3'd0) || (q_cmd.n_pass != 3'd0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_r  <= '0;
      hc_r  <= 2'd0;
      nc_r  <= 2'd0;
      inv_r <= 1'b0;
    end else if (accept) begin
      hb_r  <= hb_nxt;
      hc_r  <= hc_nxt;
      nc_r  <= nc_nxt;
      inv_r <= inv_nxt;
    end
  end

endmodule

@@ rtl/core/utf8ld_queue.sv @@
// ----------------------------------------------------------------------------
// UTF-8 lossy decoder command queue
// Two-entry FIFO decoupling the front end from the output sequencer.
// ----------------------------------------------------------------------------
module utf8ld_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  utf8ld_pkg::cmd_t     push_cmd,
  output logic                 full,
  input  logic                 pop,
  output logic                 nempty,
  output utf8ld_pkg::cmd_t     head
);

  localparam int unsigned PW = (utf8ld_pkg::QDEPTH > 1) ? $clog2(utf8ld_pkg::QDEPTH) : 1;
  localparam int unsigned CW = $clog2(utf8ld_pkg::QDEPTH + 1);

  utf8ld_pkg::cmd_t mem_r [utf8ld_pkg::QDEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;

  assign full   = cnt_r == CW'(utf8ld_pkg::QDEPTH);
  assign nempty = cnt_r != '0;
  assign head   = mem_r[rp_r];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(utf8ld_pkg::QDEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ptr_inc(wp_r);
      if (pop)  rp_r <= ptr_inc(rp_r);
      if (push && !pop)      cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

@@ rtl/core/utf8ld_back.sv @@
// ----------------------------------------------------------------------------
// UTF-8 lossy decoder output sequencer
// Expands one command into replacement and pass-through bytes, one a cycle while out_ready is high.
// ----------------------------------------------------------------------------
module utf8ld_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_nempty,
  input  utf8ld_pkg::cmd_t      q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output utf8ld_pkg::out_item_t out_data
);

  utf8ld_pkg::cmd_t cmd_r;
  logic             busy_r;
  logic [2:0]       rep_r;
  logic [1:0]       ph_r;
  logic [1:0]       pi_r;
  logic             fire;
  logic             final_b;

  assign out_valid = busy_r;
  assign fire      = busy_r && out_ready;

  // Final byte of the command: last octet of the last replacement when there
  // is nothing to pass through, otherwise the last pass-through byte.
  assign final_b = (rep_r != 3'd0)
                 ? (rep_r == 3'd1 && ph_r == 2'd2 && cmd_r.n_pass == 3'd0)
                 : ({1'b0, pi_r} == cmd_r.n_pass - 3'd1);

  always_comb begin
    out_data = '0;
    if (rep_r != 3'd0) begin
      out_data.is_replacement = 1'b1;
      case (ph_r)
        2'd0:    out_data.out_byte = utf8ld_pkg::REPL_B0;
        2'd1:    out_data.out_byte = utf8ld_pkg::REPL_B1;
        default: out_data.out_byte = utf8ld_pkg::REPL_B2;
      endcase
    end else begin
      out_data.out_byte = cmd_r.pbytes[pi_r];
    end
    out_data.last_of_run   = final_b;
    out_data.end_of_stream = final_b && cmd_r.eos;
    out_data.stream_valid  = final_b && cmd_r.sv;
  end

  assign q_pop = q_nempty && (!busy_r || (fire && final_b));

  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rep_r  <= 3'd0;
      ph_r   <= 2'd0;
      pi_r   <= 2'd0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      rep_r  <= q_head.n_rep;
      ph_r   <= 2'd0;
      pi_r   <= 2'd0;
    end else if (fire) begin
      if (final_b) begin
        busy_r <= 1'b0;
      end else if (rep_r != 3'd0) begin
        if (ph_r == 2'd2) begin
          ph_r  <= 2'd0;
          rep_r <= rep_r - 3'd1;
        end else begin
          ph_r <= ph_r + 2'd1;
        end
      end else begin
        pi_r <= pi_r + 2'd1;
      end
    end
  end

endmodule

@@ rtl/core/utf8_lossy_decoder_core.sv @@
// Path: a command is registered in the queue, then in the sequencer, which emits its bytes.
// Throughput: one output byte per cycle from the sequencer while out_ready is high;
// the two-entry command queue stalls input once full. Pending lead and
// continuation bytes are taken without a queue entry.
// Reset: synchronous, active low; clears the pending sequence, the queue and the sequencer.
// ----------------------------------------------------------------------------
// UTF-8 lossy decoder core
// Repairs a byte stream to strict UTF-8, substituting U+FFFD for bad input.
// ----------------------------------------------------------------------------
module utf8_lossy_decoder_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  utf8ld_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output utf8ld_pkg::out_item_t out_data
);

  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_nempty;
  utf8ld_pkg::cmd_t q_cmd;
  utf8ld_pkg::cmd_t q_head;

  utf8ld_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  utf8ld_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .nempty   (q_nempty),
    .head     (q_head)
  );

  utf8ld_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_nempty  (q_nempty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The end of a stream is always the final byte of its transaction.
  a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.end_of_stream |-> out_data.last_of_run)
    else $error("end_of_stream without last_of_run");

  // A stream closing on a replacement can never be reported valid.
  a_rep_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_replacement && out_data.end_of_stream
      |-> !out_data.stream_valid)
    else $error("stream reported valid on a replacement");

  // Nothing is written into the queue while it is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("command queue overflow");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 lossy decoder core testbench
// Feeds directed and random byte streams through the core and checks every
// output octet against an in-bench model of the U+FFFD repair rules, with
// random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned RUN_LIMIT    = 400000;
  localparam int unsigned STIM_ITEMS   = 130;
  localparam int unsigned CALM_TAIL    = 25;
  localparam int unsigned HOLD_AT      = 60;
  localparam int unsigned HOLD_CYCLES  = 100;
  localparam int unsigned SETTLE_TICKS = 20;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  utf8ld_pkg::in_item_t  in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  utf8ld_pkg::out_item_t out_data;

  utf8_lossy_decoder_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  utf8ld_pkg::in_item_t  byte_backlog[$];
  utf8ld_pkg::out_item_t expected_octets[$];
  utf8ld_pkg::out_item_t run_octets[$];

  // Model state of the sequence being assembled.
  logic [7:0]  held_octet [3];
  logic [1:0]  held_n;
  logic [1:0]  need_n;
  bit          repl_seen;

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned accepted_count = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  logic        holding = 1'b0;
  logic        calm = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic void put_octet(logic [7:0] b, logic rep);
    utf8ld_pkg::out_item_t r;
    r = '0;
    r.out_byte = b;
    r.is_replacement = rep;
    run_octets.push_back(r);
  endfunction

  function automatic void put_fffd();
    put_octet(utf8ld_pkg::REPL_B0, 1'b1);
    put_octet(utf8ld_pkg::REPL_B1, 1'b1);
    put_octet(utf8ld_pkg::REPL_B2, 1'b1);
    repl_seen = 1'b1;
  endfunction

  function automatic void drop_held();
    held_octet[0] = '0;
    held_octet[1] = '0;
    held_octet[2] = '0;
    held_n = '0;
    need_n = '0;
  endfunction

  function automatic void start_octet(logic [7:0] c, logic last);
    logic [1:0] extra;
    if (c < 8'h80) begin
      put_octet(c, 1'b0);
      return;
    end
    if ((c & 8'hE0) == 8'hC0) extra = 2'd1;
    else if ((c & 8'hF0) == 8'hE0) extra = 2'd2;
    else if ((c & 8'hF8) == 8'hF0) extra = 2'd3;
    else extra = 2'd0;
    if (extra == 2'd0 || last) begin
      put_fffd();
      return;
    end
    held_octet[0] = c;
    held_n = 2'd1;
    need_n = extra;
  endfunction

  // Assembles the code point of the held sequence closed by c and applies
  // the overlong, surrogate and range rules.
  function automatic bit closes_legally(logic [7:0] c);
    logic [31:0] cp;
    int          k;
    case (held_n)
      2'd1:    cp = {24'h0, held_octet[0] & 8'h1F};
      2'd2:    cp = {24'h0, held_octet[0] & 8'h0F};
      default: cp = {24'h0, held_octet[0] & 8'h07};
    endcase
    for (k = 1; k < held_n; k++)
      cp = (cp << 6) | {24'h0, held_octet[k] & utf8ld_pkg::PAYLOAD_MSK};
    cp = (cp << 6) | {24'h0, c & utf8ld_pkg::PAYLOAD_MSK};
    if (held_n == 2'd1 && cp < 32'(utf8ld_pkg::CP_MIN2)) return 1'b0;
    if (held_n == 2'd2 && cp < 32'(utf8ld_pkg::CP_MIN3)) return 1'b0;
    if (held_n == 2'd3 && cp < 32'(utf8ld_pkg::CP_MIN4)) return 1'b0;
    if (cp > 32'(utf8ld_pkg::CP_MAX)) return 1'b0;
    if (cp >= 32'(utf8ld_pkg::CP_SURR_LO) && cp <= 32'(utf8ld_pkg::CP_SURR_HI))
      return 1'b0;
    return 1'b1;
  endfunction

  function automatic void repair_byte(utf8ld_pkg::in_item_t it);
    logic [7:0]            c;
    logic                  last;
    int                    k;
    utf8ld_pkg::out_item_t r;
    c = it.in_byte;
    last = it.last_in_stream;
    run_octets.delete();
    if (held_n == 2'd0 || need_n == 2'd0) begin
      drop_held();
      start_octet(c, last);
    end else if ((c & utf8ld_pkg::CONT_MASK) != utf8ld_pkg::CONT_TAG) begin
      // Each held octet becomes a replacement, then c is decoded afresh.
      for (k = 0; k < held_n; k++) put_fffd();
      drop_held();
      start_octet(c, last);
    end else if (need_n == 2'd1) begin
      if (closes_legally(c)) begin
        for (k = 0; k < held_n; k++) put_octet(held_octet[k], 1'b0);
        put_octet(c, 1'b0);
      end else begin
        for (k = 0; k <= held_n; k++) put_fffd();
      end
      drop_held();
    end else begin
      if (held_n < 2'd3) held_octet[held_n] = c;
      held_n = held_n + 2'd1;
      need_n = need_n - 2'd1;
      if (last) begin
        for (k = 0; k < held_n; k++) put_fffd();
        drop_held();
      end
    end
    if (run_octets.size() > 0) begin
      r = run_octets[run_octets.size() - 1];
      r.last_of_run = 1'b1;
      if (last) begin
        r.end_of_stream = 1'b1;
        r.stream_valid = !repl_seen;
      end
      run_octets[run_octets.size() - 1] = r;
    end
    if (last) begin
      drop_held();
      repl_seen = 1'b0;
    end
    foreach (run_octets[i]) expected_octets.push_back(run_octets[i]);
  endfunction

  // ------------------------------------------------------------ stimulus

  task automatic push_octet(logic [7:0] b, logic last);
    utf8ld_pkg::in_item_t it;
    it.in_byte = b;
    it.last_in_stream = last;
    byte_backlog.push_back(it);
  endtask

  task automatic push_seq(logic [3:0][7:0] s, int n, bit last);
    int k;
    for (k = 0; k < n; k++) push_octet(s[k], last && (k == n - 1));
  endtask

  function automatic logic [3:0][7:0] encode_cp(logic [20:0] cp, int len);
    logic [3:0][7:0] s;
    s = '0;
    case (len)
      1: s[0] = {1'b0, cp[6:0]};
      2: begin
        s[0] = {3'b110, cp[10:6]};
        s[1] = {2'b10, cp[5:0]};
      end
      3: begin
        s[0] = {4'b1110, cp[15:12]};
        s[1] = {2'b10, cp[11:6]};
        s[2] = {2'b10, cp[5:0]};
      end
      default: begin
        s[0] = {5'b11110, cp[20:18]};
        s[1] = {2'b10, cp[17:12]};
        s[2] = {2'b10, cp[11:6]};
        s[3] = {2'b10, cp[5:0]};
      end
    endcase
    return s;
  endfunction

  function automatic logic [7:0] any_cont();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  initial begin
    int              pick;
    int              len;
    bit              end_here;
    logic [20:0]     cp;
    logic [3:0][7:0] s;

    drop_held();
    repl_seen = 1'b0;

    // Directed part: ASCII extremes, good and bad multi-byte forms.
    push_octet(8'h00, 1'b0);
    push_octet(8'h7F, 1'b0);
    push_seq({8'h00, 8'h00, 8'h80, 8'hC2}, 2, 1'b0);          // smallest two-byte
    push_seq({8'h00, 8'h80, 8'hA0, 8'hED}, 3, 1'b0);          // surrogate
    push_seq({8'h80, 8'h80, 8'h90, 8'hF4}, 4, 1'b0);          // above U+10FFFF
    push_seq({8'h00, 8'h00, 8'h80, 8'hC0}, 2, 1'b0);          // overlong
    push_octet(8'h80, 1'b0);                                   // stray continuation
    push_octet(8'hFF, 1'b0);                                   // never a lead
    push_seq({8'h00, 8'h00, 8'h41, 8'hE2}, 2, 1'b0);          // lead, then ASCII
    push_seq({8'h00, 8'h8F, 8'h9F, 8'hF0}, 3, 1'b1);          // cut short at the end
    push_seq({8'hBF, 8'hBF, 8'h8F, 8'hF4}, 4, 1'b0);          // largest code point
    push_octet(8'hC2, 1'b1);                                   // lead as last byte

    while (byte_backlog.size() < STIM_ITEMS) begin
      pick = $urandom_range(0, 99);
      end_here = ($urandom_range(0, 5) == 0);
      len = $urandom_range(1, 4);
      case (len)
        1: cp = 21'($urandom_range(0, 'h7F));
        2: cp = 21'($urandom_range('h80, 'h7FF));
        3: begin
          cp = 21'($urandom_range('h800, 'hFFFF));
          if (cp >= utf8ld_pkg::CP_SURR_LO && cp <= utf8ld_pkg::CP_SURR_HI)
            cp = cp ^ 21'h2000;
        end
        default: cp = 21'($urandom_range('h10000, 'h10FFFF));
      endcase
      s = encode_cp(cp, len);
      if (pick < 55) begin
        push_seq(s, len, end_here);
      end else if (pick < 70) begin
        push_octet(8'($urandom_range(0, 255)), end_here);
      end else if (pick < 82) begin
        // Truncated sequence: some of its continuations never arrive.
        if (len == 1) begin
          s = encode_cp(cp | 21'h80, 2);
          len = 2;
        end
        push_seq(s, $urandom_range(1, len - 1), end_here);
      end else begin
        s = {any_cont(), any_cont(), any_cont(), 8'h00};
        case ($urandom_range(0, 5))
          0: begin s[0] = 8'hC0 | 8'($urandom_range(0, 1)); len = 2; end
          1: begin s[0] = 8'hE0; s[1] = 8'h80 | 8'($urandom_range(0, 'h1F)); len = 3; end
          2: begin s[0] = 8'hED; s[1] = 8'hA0 | 8'($urandom_range(0, 'h1F)); len = 3; end
          3: begin s[0] = 8'hF0; s[1] = 8'h80 | 8'($urandom_range(0, 'hF)); len = 4; end
          4: begin s[0] = 8'hF4; s[1] = 8'h90 + 8'($urandom_range(0, 'h2F)); len = 4; end
          default: begin s[0] = 8'hF5 + 8'($urandom_range(0, 2)); len = 4; end
        endcase
        push_seq(s, len, end_here);
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_backlog.size() != 0 || in_valid) @(posedge clk);
    while (expected_octets.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // -------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        repair_byte(in_data);
        accepted_count <= accepted_count + 1;
      end
      if (in_valid && !in_ready) begin
        // The current transaction waits, payload held.
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (byte_backlog.size() > 0) begin
        in_data <= byte_backlog.pop_front();
        in_valid <= 1'b1;
        if (!calm && !holding && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 14);
      end else begin
        in_valid <= 1'b0;
      end
      calm <= (byte_backlog.size() < CALM_TAIL);
    end
  end

  // ------------------------------------------------------------- monitor

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    utf8ld_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      holding <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_octets.size() == 0) begin
          $error("out_byte: expected none, got %0h", out_data.out_byte);
          errors++;
        end else begin
          want = expected_octets.pop_front();
          check_field("out_byte", want.out_byte, out_data.out_byte);
          check_field("is_replacement", want.is_replacement, out_data.is_replacement);
          check_field("last_of_run", want.last_of_run, out_data.last_of_run);
          check_field("end_of_stream", want.end_of_stream, out_data.end_of_stream);
          check_field("stream_valid", want.stream_valid, out_data.stream_valid);
        end
      end
      // One long hold-off lets the command queue fill and stall the input.
      if (!hold_done && accepted_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
        holding <= 1'b1;
      end else begin
        holding <= 1'b0;
        if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
          if (!calm && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 14);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

@@ utf8_lossy_decoder_core.f @@
rtl/core/utf8ld_pkg.sv
rtl/core/utf8ld_front.sv
rtl/core/utf8ld_queue.sv
rtl/core/utf8ld_back.sv
rtl/core/utf8_lossy_decoder_core.sv
tb/tb.sv
